// ===== design/binary_min_heap_priority_queue_defines.svh =====
// Assertion macros shared by the priority queue checker.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bmhpq_pkg.sv =====
// Shared types and constants of the binary min-heap priority queue.
`default_nettype none

package bmhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CH_W      = ADDR_W + 1;
    localparam int KEY_W     = 32;
    localparam int OUT_CNT_W = 7;

    // Result item layout on the master tdata bus.
    localparam int OUT_KEY_LSB   = 0;
    localparam int OUT_CNT_LSB   = OUT_KEY_LSB + KEY_W;
    localparam int OUT_EMPTY_BIT = OUT_CNT_LSB + OUT_CNT_W;
    localparam int OUT_REJ_BIT   = OUT_EMPTY_BIT + 1;
    localparam int OUT_USED_W    = OUT_REJ_BIT + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } t_opcode;

endpackage

`default_nettype wire

// ===== design/bmhpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bmhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue of signed Q16.16 keys, one memory, one item at a time.
//
// Each input item is an insert (tuser = 0, key on tdata) or an extract of the
// minimum (tuser = 1, tdata ignored), and each gives exactly one result item
// carrying the root key, the number of keys held, an empty flag and a reject
// flag. An insert into a full queue and an extract from an empty queue leave
// the contents unchanged and come back with the reject flag set. The keys sit
// in one synchronous RAM of CAPACITY entries; the key being placed is held in
// a register while a hole walks up or down the tree, and it is written into
// the RAM only once its final slot is known. The block takes one item at a
// time; the pace of each sift is set by the single read port of the key RAM,
// which returns one key per cycle. A finished result waits in an output
// register, so the next item is taken while the previous result is still
// unclaimed. The RAM needs no clearing after reset; only slots below the
// count are ever read.
`default_nettype none

module binary_min_heap_priority_queue (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [bmhpq_pkg::KEY_W-1:0]        s_axis_tdata,  // key
    input  wire logic                               s_axis_tuser,  // opcode
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // min_key, entry_count, queue_empty, rejected, zero fill
    output logic      [bmhpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int AW = bmhpq_pkg::ADDR_W;
    localparam int CW = bmhpq_pkg::CNT_W;
    localparam int HW = bmhpq_pkg::CH_W;

    // One-hot control states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,  // waiting for an item
        S_UP   = 6'b000010,  // parent key arriving during sift-up
        S_LAST = 6'b000100,  // last key arriving at the start of an extract
        S_DNL  = 6'b001000,  // left child arriving during sift-down
        S_DNR  = 6'b010000,  // right child arriving during sift-down
        S_PUT  = 6'b100000   // moving key written into its final slot
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_pos, n_pos;
    bmhpq_pkg::t_key         r_key, n_key;
    bmhpq_pkg::t_key         r_left, n_left;
    bmhpq_pkg::t_key         r_root;
    logic                    r_rej, n_rej;
    logic                    r_fin, n_fin;
    logic                    r_out_valid;
    logic [bmhpq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [bmhpq_pkg::OUT_DATA_W-1:0] c_out_word;

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    bmhpq_pkg::t_key         w_wdata;
    logic [AW-1:0]           w_raddr;
    logic [bmhpq_pkg::KEY_W-1:0] w_rdata;
    bmhpq_pkg::t_key         c_rkey;

    logic                    c_accept;
    logic                    c_out_free;
    logic [HW-1:0]           c_count_ext;
    logic [HW-1:0]           c_left_idx;
    logic [HW-1:0]           c_right_idx;
    logic [AW-1:0]           c_parent;
    logic                    c_decide;
    bmhpq_pkg::t_key         c_best_val;
    logic [AW-1:0]           c_best_idx;
    logic [HW-1:0]           c_next_left;

    bmhpq_ram #(
        .WIDTH (bmhpq_pkg::KEY_W),
        .DEPTH (bmhpq_pkg::CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign c_rkey      = bmhpq_pkg::t_key'(w_rdata);
    assign c_out_free  = !r_out_valid || m_axis_tready;
    // A pending result must leave before a new item is taken.
    assign s_axis_tready = (r_state == S_IDLE) && !r_fin;
    assign c_accept    = s_axis_tvalid && s_axis_tready;
    assign c_count_ext = HW'(r_count);
    assign c_left_idx  = {r_pos, 1'b1};
    assign c_right_idx = c_left_idx + HW'(1);
    assign c_parent    = AW'((r_pos - AW'(1)) >> 1);

    // Smaller child, left on a tie. S_DNL decides alone only when no right child exists.
    always_comb begin
        c_decide   = 1'b0;
        c_best_val = c_rkey;
        c_best_idx = AW'(c_left_idx);
        if (r_state == S_DNL && !(c_right_idx < c_count_ext)) begin
            c_decide = 1'b1;
        end else if (r_state == S_DNR) begin
            c_decide = 1'b1;
            if (c_rkey < r_left) begin
                c_best_idx = AW'(c_right_idx);
            end else begin
                c_best_val = r_left;
            end
        end
    end
    assign c_next_left = {c_best_idx, 1'b1};

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_key   = r_key;
        n_left  = r_left;
        n_rej   = r_rej;
        n_fin   = r_fin;
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_key;
        w_raddr = c_parent;

        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_rej = 1'b0;
                    if (bmhpq_pkg::t_opcode'(s_axis_tuser) == bmhpq_pkg::OP_INSERT) begin
                        if (r_count == CW'(bmhpq_pkg::CAPACITY)) begin
                            n_rej = 1'b1;
                            n_fin = 1'b1;
                        end else begin
                            n_key   = bmhpq_pkg::t_key'(s_axis_tdata);
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                w_raddr = AW'((r_count - CW'(1)) >> 1);
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_rej = 1'b1;
                            n_fin = 1'b1;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_pos   = '0;
                            if (r_count == CW'(1)) begin
                                n_fin = 1'b1;
                            end else begin
                                w_raddr = AW'(r_count - CW'(1));
                                n_state = S_LAST;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                if (r_key < c_rkey) begin
                    // Parent drops into the hole; the hole climbs.
                    w_we    = 1'b1;
                    w_wdata = c_rkey;
                    n_pos   = c_parent;
                    w_raddr = AW'((c_parent - AW'(1)) >> 1);
                    if (c_parent == '0) begin
                        n_state = S_PUT;
                    end
                end else begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                end
            end
            S_LAST: begin
                n_key = c_rkey;
                if (HW'(1) < c_count_ext) begin
                    w_raddr = AW'(1);
                    n_state = S_DNL;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DNL, S_DNR: begin
                if (!c_decide) begin
                    n_left  = c_rkey;
                    w_raddr = AW'(c_right_idx);
                    n_state = S_DNR;
                end else if (c_best_val < r_key) begin
                    // Smaller child rises into the hole; the hole descends.
                    w_we    = 1'b1;
                    w_wdata = c_best_val;
                    n_pos   = c_best_idx;
                    if (c_next_left < c_count_ext) begin
                        w_raddr = AW'(c_next_left);
                        n_state = S_DNL;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                n_state = S_IDLE;
                n_fin   = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The finished result moves to the output register when it is free.
        if (r_fin && c_out_free) begin
            n_fin = 1'b0;
        end
    end

    // Result word: root key, count, empty flag and reject flag, zero filled.
    always_comb begin
        c_out_word = '0;
        c_out_word[bmhpq_pkg::OUT_KEY_LSB +: bmhpq_pkg::KEY_W] =
            (r_count != '0) ? r_root : '0;
        c_out_word[bmhpq_pkg::OUT_CNT_LSB +: bmhpq_pkg::OUT_CNT_W] =
            bmhpq_pkg::OUT_CNT_W'(r_count);
        c_out_word[bmhpq_pkg::OUT_EMPTY_BIT] = (r_count == '0);
        c_out_word[bmhpq_pkg::OUT_REJ_BIT]   = r_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_fin   <= n_fin;
            if (r_fin && c_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_left <= n_left;
        r_rej  <= n_rej;
        // The root key is kept beside the RAM so the result needs no extra read.
        if (w_we && w_waddr == '0) begin
            r_root <= w_wdata;
        end
        if (r_fin && c_out_free) begin
            r_out_data <= c_out_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== design/bmhpq_checker.sv =====
// Port-level checker of the priority queue, bound to the top level.
`default_nettype none
`include "binary_min_heap_priority_queue_defines.svh"

module bmhpq_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [bmhpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic                              w_empty;
    logic [bmhpq_pkg::OUT_CNT_W-1:0]   w_count;
    logic [bmhpq_pkg::KEY_W-1:0]       w_min;
    logic                              w_in_acc;

    assign w_empty  = m_axis_tdata[bmhpq_pkg::OUT_EMPTY_BIT];
    assign w_count  = m_axis_tdata[bmhpq_pkg::OUT_CNT_LSB +: bmhpq_pkg::OUT_CNT_W];
    assign w_min    = m_axis_tdata[bmhpq_pkg::OUT_KEY_LSB +: bmhpq_pkg::KEY_W];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result keeps its value.
    `BMHPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata),
        "result changed while stalled")
    // The empty flag agrees with the count.
    `BMHPQ_ASSERT_NOW(a_empty_count, i_clk, i_rst_n,
        m_axis_tvalid, w_empty == (w_count == '0),
        "empty flag and count disagree")
    // An empty queue reports a zero root key.
    `BMHPQ_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n,
        m_axis_tvalid && w_empty, w_min == '0,
        "empty queue reports a key")
    // One item at a time: the block is busy right after taking an item.
    `BMHPQ_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n,
        w_in_acc, !s_axis_tready,
        "item taken while busy")

endmodule

bind binary_min_heap_priority_queue bmhpq_checker u_bmhpq_checker (.*);

`default_nettype wire
